// File: hw/rtl/fixed_block_free_list_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block pool allocator
// Shared concurrent assertion forms used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBFL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FBFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg
// Types and constants shared by the block pool allocator modules.
// ----------------------------------------------------------------------------
package fbfl_pkg;

   localparam int SIZE_W         = 13;
   localparam int OP_W           = 2;
   localparam int INDEX_W        = 8;
   localparam int OFFSET_W       = 12;
   localparam int COUNT_W        = 9;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int BLOCK_SIZE_MIN = 16;
   localparam int BLOCK_SIZE_MAX = 4096;

   localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET = 13'd32;
   localparam logic [SIZE_W-1:0] SIZE_LOW         = 13'd16;
   localparam logic [SIZE_W-1:0] SIZE_HIGH        = 13'd4096;

   // Register index, taken from paddr[2] (byte address 4*i).
   localparam logic REG_BLOCK_SIZE = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_INIT    = 2'd0,
      OP_ALLOC   = 2'd1,
      OP_FREE    = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALLOC_RD,
      ST_INIT_RUN,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic                ok;
      logic [INDEX_W-1:0]  granted_index;
      logic [OFFSET_W-1:0] byte_offset;
      logic [COUNT_W-1:0]  blocks_free;
   } result_type;

endpackage

// File: hw/rtl/fbfl_ram.sv
// ----------------------------------------------------------------------------
// fbfl_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fbfl_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/fbfl_csr.sv
// ----------------------------------------------------------------------------
// fbfl_csr
// Configuration register file with an APB-style port. Holds the block size
// and presents it saturated to the supported range.
// ----------------------------------------------------------------------------
module fbfl_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fbfl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [fbfl_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [fbfl_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [fbfl_pkg::SIZE_W-1:0]       block_size
);

   logic [fbfl_pkg::SIZE_W-1:0] size_ff;
   logic [fbfl_pkg::SIZE_W-1:0] size_in;
   logic                        hit;

   assign csr_pready = 1'b1;
   assign hit        = (csr_paddr[2] == fbfl_pkg::REG_BLOCK_SIZE);

   always_comb begin
      size_in = size_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit) begin
         size_in = csr_pwdata[fbfl_pkg::SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= fbfl_pkg::BLOCK_SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (hit) begin
         csr_prdata = fbfl_pkg::CSR_DATA_W'(size_ff);
      end
   end

   always_comb begin
      priority if (size_ff < fbfl_pkg::SIZE_LOW) begin
         block_size = fbfl_pkg::SIZE_LOW;
      end else if (size_ff > fbfl_pkg::SIZE_HIGH) begin
         block_size = fbfl_pkg::SIZE_HIGH;
      end else begin
         block_size = size_ff;
      end
   end

endmodule

// File: hw/rtl/fbfl_ctrl.sv
// ----------------------------------------------------------------------------
// fbfl_ctrl
// Free list sequencer: keeps head, free count and block total, drives the
// link memory, and holds the result register toward the output channel.
// ----------------------------------------------------------------------------
`include "fixed_block_free_list_allocator_core_assert.svh"

module fbfl_ctrl #(
   parameter int POOL_BYTES = 4096,
   parameter int MAX_BLOCKS = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [fbfl_pkg::OP_W-1:0]              req_op,
   input  logic [fbfl_pkg::INDEX_W-1:0]           req_index,
   input  logic [fbfl_pkg::SIZE_W-1:0]            block_size,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output fbfl_pkg::result_type                   rsp_result,
   output logic                                   ram_wr_en,
   output logic [$clog2(MAX_BLOCKS)-1:0]          ram_wr_addr,
   output logic [$clog2(MAX_BLOCKS+1)-1:0]        ram_wr_data,
   output logic [$clog2(MAX_BLOCKS)-1:0]          ram_rd_addr,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0]        ram_rd_data
);

   localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CMP_W  = (LINK_W > fbfl_pkg::INDEX_W) ? LINK_W : fbfl_pkg::INDEX_W;
   localparam int ACC_W  = $clog2(POOL_BYTES + 2 * fbfl_pkg::BLOCK_SIZE_MAX + 1);
   localparam int PROD_W = LINK_W + fbfl_pkg::SIZE_W;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);
   localparam logic [ACC_W-1:0]  POOL_END  = ACC_W'(POOL_BYTES);

   fbfl_pkg::state_type  state_ff, state_in;
   logic [LINK_W-1:0]    head_ff, head_in;
   logic [LINK_W-1:0]    count_ff, count_in;
   logic [LINK_W-1:0]    total_ff, total_in;
   logic [IDX_W-1:0]     ptr_ff, ptr_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   fbfl_pkg::result_type rsp_ff, rsp_in;
   fbfl_pkg::result_type hold_ff, hold_in;

   fbfl_pkg::result_type res;
   logic                 done;
   logic                 out_free;
   logic                 req_fire;
   logic [PROD_W-1:0]    prod;
   logic [ACC_W-1:0]     next_end;
   logic [LINK_W-1:0]    ptr_next;
   logic                 more;

   assign req_ready = (state_ff == fbfl_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign prod      = PROD_W'(head_ff) * PROD_W'(block_size);
   assign next_end  = acc_ff + ACC_W'(block_size);
   assign ptr_next  = LINK_W'(ptr_ff) + LINK_W'(1);
   assign more      = (next_end <= POOL_END) && (ptr_next < NULL_LINK);

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      total_in    = total_ff;
      ptr_in      = ptr_ff;
      acc_in      = acc_ff;
      hold_in     = hold_ff;
      res         = '0;
      res.ok      = 1'b1;
      done        = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = ptr_ff;
      ram_wr_data = NULL_LINK;
      ram_rd_addr = IDX_W'(head_ff);

      unique case (state_ff)
         fbfl_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (fbfl_pkg::op_type'(req_op))
                  fbfl_pkg::OP_INIT: begin
                     if (ACC_W'(block_size) <= POOL_END) begin
                        ptr_in   = '0;
                        acc_in   = ACC_W'(block_size);
                        state_in = fbfl_pkg::ST_INIT_RUN;
                     end else begin
                        head_in  = NULL_LINK;
                        count_in = '0;
                        total_in = '0;
                        done     = 1'b1;
                     end
                  end
                  fbfl_pkg::OP_ALLOC: begin
                     if (count_ff == '0 || head_ff >= NULL_LINK) begin
                        res.ok = 1'b0;
                        done   = 1'b1;
                     end else begin
                        state_in = fbfl_pkg::ST_ALLOC_RD;
                     end
                  end
                  fbfl_pkg::OP_FREE: begin
                     if (CMP_W'(req_index) >= CMP_W'(total_ff)) begin
                        res.ok = 1'b0;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = IDX_W'(req_index);
                        ram_wr_data = head_ff;
                        head_in     = LINK_W'(req_index);
                        if (count_ff < NULL_LINK) begin
                           count_in = count_ff + LINK_W'(1);
                        end
                     end
                     done = 1'b1;
                  end
                  fbfl_pkg::OP_RELEASE: begin
                     head_in  = NULL_LINK;
                     count_in = '0;
                     total_in = '0;
                     done     = 1'b1;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         fbfl_pkg::ST_ALLOC_RD: begin
            res.granted_index = fbfl_pkg::INDEX_W'(head_ff);
            res.byte_offset   = prod[fbfl_pkg::OFFSET_W-1:0];
            head_in           = ram_rd_data;
            count_in          = count_ff - LINK_W'(1);
            done              = 1'b1;
         end
         fbfl_pkg::ST_INIT_RUN: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff;
            ram_wr_data = more ? ptr_next : NULL_LINK;
            if (more) begin
               ptr_in = IDX_W'(ptr_next);
               acc_in = next_end;
            end else begin
               head_in  = '0;
               count_in = ptr_next;
               total_in = ptr_next;
               done     = 1'b1;
            end
         end
         fbfl_pkg::ST_HOLD: begin
         end
         default: begin
            state_in = fbfl_pkg::ST_IDLE;
         end
      endcase

      res.blocks_free = fbfl_pkg::COUNT_W'(count_in);

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == fbfl_pkg::ST_HOLD) begin
         if (out_free) begin
            rsp_in       = hold_ff;
            rsp_valid_in = 1'b1;
            state_in     = fbfl_pkg::ST_IDLE;
         end
      end else if (done) begin
         if (out_free) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = fbfl_pkg::ST_IDLE;
         end else begin
            hold_in  = res;
            state_in = fbfl_pkg::ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbfl_pkg::ST_IDLE;
         head_ff      <= NULL_LINK;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   `FBFL_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= NULL_LINK, "free count above pool size")
   `FBFL_ASSERT_SAME(a_total_bound, clock, reset, 1'b1, total_ff <= NULL_LINK, "block total above pool size")
   `FBFL_ASSERT_SAME(a_alloc_head, clock, reset, state_ff == fbfl_pkg::ST_ALLOC_RD, head_ff < NULL_LINK, "alloc read with null head")
   `FBFL_ASSERT_SAME(a_hold_full, clock, reset, state_ff == fbfl_pkg::ST_HOLD, rsp_valid_ff, "held result while output empty")
   `FBFL_ASSERT_NEXT(a_accept_busy, clock, reset, req_fire, (state_ff != fbfl_pkg::ST_IDLE) || rsp_valid_ff, "accepted request produced nothing")

endmodule

// File: hw/rtl/fixed_block_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_core
// Fixed-size block pool with a LIFO free list of next-links held in RAM.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream: req_tuser carries the operation (init,
// alloc, free, release) and req_tdata the block index for a free. Every
// request gives exactly one transfer on the rsp_ stream with the ok flag in
// rsp_tuser and the granted index, byte offset and free count in rsp_tdata.
// The user must write the block size through the csr_ port only while no
// request is open; the block does not enforce this. Free, release and failed
// alloc finish in the cycle they are accepted, so a new request can follow in
// the next cycle unless the output stalls. A successful alloc passes through
// ALLOC_RD to read the head's next-link from the registered link RAM. Init
// writes one link per cycle, one per block. The result sits in an output
// register; if the receiver stalls while it is full, the next result waits in
// a hold register and no new request is accepted until that result moves out.
// Reset empties the pool and sets the block size to 32; the link RAM is not
// cleared, since every link is written by init before it can be read.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_core #(
   parameter int POOL_BYTES = 4096,
   parameter int MAX_BLOCKS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] block_index
   input  logic [1:0]                        req_tuser,   // [1:0] op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] granted_index, [19:8] byte_offset, [28:20] blocks_free, [31:29] zero
   output logic [31:0]                       rsp_tdata,
   output logic                              rsp_tuser,   // [0] ok
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fbfl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [fbfl_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [fbfl_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W  = $clog2(MAX_BLOCKS);

   logic [fbfl_pkg::SIZE_W-1:0] block_size;
   fbfl_pkg::result_type        result;
   logic                        ram_wr_en;
   logic [IDX_W-1:0]            ram_wr_addr;
   logic [LINK_W-1:0]           ram_wr_data;
   logic [IDX_W-1:0]            ram_rd_addr;
   logic [LINK_W-1:0]           ram_rd_data;

   fbfl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .block_size  (block_size)
   );

   fbfl_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fbfl_ctrl #(
      .POOL_BYTES (POOL_BYTES),
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_index   (req_tdata),
      .block_size  (block_size),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_result  (result),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   assign rsp_tdata = {3'b000, result.blocks_free, result.byte_offset, result.granted_index};
   assign rsp_tuser = result.ok;

endmodule
